### hw/rtl/tsvf_pkg.sv
package tsvf_pkg;

  localparam int NUMBER_DIGITS = 6;
  localparam int BCD_W = 4 * NUMBER_DIGITS;
  localparam int NUM_LEN = NUMBER_DIGITS + 1;
  localparam int STEP_W = $clog2(NUM_LEN + 4);
  localparam int CFG_IDX_W = 3;

  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CARET = 8'h5e;
  localparam logic [7:0] CH_I = 8'h49;
  localparam logic [7:0] CH_M = 8'h4d;
  localparam logic [7:0] CH_DASH = 8'h2d;
  localparam logic [7:0] CH_QMARK = 8'h3f;
  localparam logic [6:0] CH_DEL = 7'h7f;
  localparam logic [6:0] CTRL_LAST = 7'h1f;
  localparam logic [7:0] CARET_OFS = 8'h40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUMBER_ALL = 3'd0,
    CFG_NUMBER_NONBLANK = 3'd1,
    CFG_SQUEEZE = 3'd2,
    CFG_SHOW_ENDS = 3'd3,
    CFG_SHOW_TABS = 3'd4,
    CFG_SHOW_NONPRINT = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_of_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic             num_en;
    logic [BCD_W-1:0] bcd;
    logic [3:0][7:0]  cb;
    logic [1:0]       cnt;
  } job_t;

  function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
    logic [BCD_W-1:0] r;
    logic             nines;
    logic             carry;
    r = v;
    nines = 1'b1;
    carry = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (v[4*i +: 4] != 4'd9) nines = 1'b0;
    end
    if (!nines) begin
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
        if (carry) begin
          if (v[4*i +: 4] >= 4'd9) begin
            r[4*i +: 4] = 4'd0;
          end else begin
            r[4*i +: 4] = v[4*i +: 4] + 4'd1;
            carry = 1'b0;
          end
        end
      end
    end
    return r;
  endfunction

endpackage

### hw/rtl/tsvf_front.sv
module tsvf_front import tsvf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data,
  input  logic                 in_fire,
  input  in_item_t             in_data,
  output logic                 job_push,
  output job_t                 job
);

  logic num_all_r, num_nb_r, squeeze_r, show_ends_r, show_tabs_r, show_np_r;
  logic at_start_r, at_start_nxt;
  logic blank_r, blank_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;

  logic             als;
  logic             last_blank;
  logic [BCD_W-1:0] bcd_eff;
  logic             nb;
  logic             drop;
  logic             num;
  logic [7:0]       c;
  logic [6:0]       c7;
  logic             caret;
  logic [7:0]       lo0, lo1;

  assign c = in_data.in_byte;
  assign c7 = c[6:0];

  always_comb begin
    als = in_data.first_of_file | at_start_r;
    last_blank = in_data.first_of_file ? 1'b0 : blank_r;
    bcd_eff = in_data.first_of_file ? '0 : bcd_r;
    nb = (c == CH_LF);
    drop = als && squeeze_r && nb && last_blank;
    num = als && !drop && ((num_nb_r && !nb) || (num_all_r && !num_nb_r));
    at_start_nxt = at_start_r;
    blank_nxt = blank_r;
    bcd_nxt = bcd_r;
    if (in_fire) begin
      bcd_nxt = num ? bcd_inc(bcd_eff) : bcd_eff;
      if (als) blank_nxt = nb;
      at_start_nxt = drop ? 1'b1 : nb;
    end
  end

  always_comb begin
    caret = (c7 <= CTRL_LAST) || (c7 == CH_DEL);
    lo0 = caret ? CH_CARET : {1'b0, c7};
    lo1 = (c7 == CH_DEL) ? CH_QMARK : ({1'b0, c7} + CARET_OFS);
    job.num_en = num;
    job.bcd = bcd_nxt;
    job.cb = {4{c}};
    job.cnt = 2'd0;
    if (nb) begin
      if (show_ends_r) begin
        job.cb[0] = CH_DOLLAR;
        job.cb[1] = CH_LF;
        job.cnt = 2'd1;
      end
    end else if (c == CH_TAB) begin
      if (show_tabs_r) begin
        job.cb[0] = CH_CARET;
        job.cb[1] = CH_I;
        job.cnt = 2'd1;
      end
    end else if (show_np_r) begin
      if (c[7]) begin
        job.cb[0] = CH_M;
        job.cb[1] = CH_DASH;
        job.cb[2] = lo0;
        job.cb[3] = lo1;
        job.cnt = caret ? 2'd3 : 2'd2;
      end else begin
        job.cb[0] = lo0;
        job.cb[1] = lo1;
        job.cnt = caret ? 2'd1 : 2'd0;
      end
    end
  end

  assign job_push = in_fire && !drop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r <= 1'b1;
      blank_r <= 1'b0;
      bcd_r <= '0;
    end else begin
      at_start_r <= at_start_nxt;
      blank_r <= blank_nxt;
      bcd_r <= bcd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_all_r <= 1'b0;
      num_nb_r <= 1'b0;
      squeeze_r <= 1'b0;
      show_ends_r <= 1'b0;
      show_tabs_r <= 1'b0;
      show_np_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_NUMBER_ALL: num_all_r <= cfg_data;
        CFG_NUMBER_NONBLANK: num_nb_r <= cfg_data;
        CFG_SQUEEZE: squeeze_r <= cfg_data;
        CFG_SHOW_ENDS: show_ends_r <= cfg_data;
        CFG_SHOW_TABS: show_tabs_r <= cfg_data;
        CFG_SHOW_NONPRINT: show_np_r <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/tsvf_jobq.sv
module tsvf_jobq import tsvf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_job = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### hw/rtl/tsvf_back.sv
module tsvf_back import tsvf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  job_t      head_job,
  output logic      job_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              lead_r, lead_nxt;
  out_item_t         obuf_r [2];
  logic              owp_r, orp_r;
  logic [1:0]        ocnt_r;
  logic              ofull;
  logic              fire;
  logic              oread;
  logic [3:0]        d;
  logic              blank_digit;
  logic [STEP_W-1:0] ci_full;
  logic [1:0]        ci;
  out_item_t         nxt_item;

  assign ofull = (ocnt_r == 2'd2);
  assign out_empty = (ocnt_r == 2'd0);
  assign out_data = obuf_r[orp_r];
  assign oread = out_pop && !out_empty;
  assign fire = head_valid && !ofull;

  always_comb begin
    d = 4'd0;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (STEP_W'(NUMBER_DIGITS - 1 - i) == step_r) d = head_job.bcd[4*i +: 4];
    end
    blank_digit = lead_r && (d == 4'd0) && (step_r != STEP_W'(NUMBER_DIGITS - 1));
    ci_full = head_job.num_en ? (step_r - STEP_W'(NUM_LEN)) : step_r;
    ci = ci_full[1:0];
    nxt_item.last_of_run = 1'b0;
    lead_nxt = lead_r;
    if (head_job.num_en && (step_r < STEP_W'(NUMBER_DIGITS))) begin
      nxt_item.out_byte = blank_digit ? CH_SPACE : (CH_ZERO + {4'd0, d});
      lead_nxt = blank_digit;
    end else if (head_job.num_en && (step_r == STEP_W'(NUMBER_DIGITS))) begin
      nxt_item.out_byte = CH_TAB;
    end else begin
      nxt_item.out_byte = head_job.cb[ci];
      nxt_item.last_of_run = (ci == head_job.cnt);
    end
    step_nxt = step_r;
    if (fire) begin
      if (nxt_item.last_of_run) begin
        step_nxt = '0;
        lead_nxt = 1'b1;
      end else begin
        step_nxt = step_r + STEP_W'(1);
      end
    end else begin
      lead_nxt = lead_r;
    end
  end

  assign job_pop = fire && nxt_item.last_of_run;

  always_ff @(posedge clk) begin
    if (fire) obuf_r[owp_r] <= nxt_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      lead_r <= 1'b1;
      owp_r <= 1'b0;
      orp_r <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      step_r <= step_nxt;
      lead_r <= lead_nxt;
      if (fire) owp_r <= ~owp_r;
      if (oread) orp_r <= ~orp_r;
      ocnt_r <= ocnt_r + {1'b0, fire} - {1'b0, oread};
    end
  end

endmodule

### hw/rtl/text_stream_visible_formatter_top.sv
// Text stream formatter: squeezes blank lines, numbers lines, shows
// line ends, tabs and non-printing bytes in visible form.
// Input queue side: in_data is taken when in_push is high and in_full low.
// Output queue side: the oldest byte sits on out_data while out_empty is
// low; out_pop takes it. last_of_run marks the final byte for an input.
// Config: cfg_index/cfg_data written when cfg_valid and cfg_ready; always
// ready. Write only while no input bytes are still being formatted.
// Path: an input byte is registered as a job in the job queue, then each of
// its output bytes is registered in the output buffer before out_data.
// Throughput: one output byte per cycle while the output buffer has room,
// set by the back-end sequencer, which emits an input's bytes in turn,
// so plain bytes stream one per cycle; a numbered line start is 8-11 bytes.
// A two-entry job queue decouples front and back; in_full rises when it
// fills. When the receiver stalls, the two-entry output buffer fills and
// the sequencer, then the job queue, then the input side hold.
// Reset (rst_n low at a clock edge) empties both queues, clears all
// options, zeroes the line counter and starts a fresh line.
module text_stream_visible_formatter_top import tsvf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data,
  input  logic                 in_push,
  output logic                 in_full,
  input  in_item_t             in_data,
  output logic                 out_empty,
  input  logic                 out_pop,
  output out_item_t            out_data
);

  logic job_push, job_pop, head_valid;
  job_t job, head_job;

  assign cfg_ready = 1'b1;

  tsvf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_fire   (in_push && !in_full),
    .in_data   (in_data),
    .job_push  (job_push),
    .job       (job)
  );

  tsvf_jobq u_jobq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_job   (job),
    .full       (in_full),
    .pop        (job_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  tsvf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .job_pop    (job_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_data   (out_data)
  );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tsvf_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_ITEMS = 380;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = {CFG_IDX_W{1'b1}};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_NUMBER_ALL;
  logic                 cfg_data = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  in_item_t             in_data = '0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  out_item_t            out_data;

  text_stream_visible_formatter_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_push(in_push),
    .in_full(in_full),
    .in_data(in_data),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  in_item_t   text_q[$];
  out_item_t  fmt_expect[$];
  logic [7:0] run_q[$];

  // formatter mirror
  logic             opt_number_all = 1'b0;
  logic             opt_nonblank = 1'b0;
  logic             opt_squeeze = 1'b0;
  logic             opt_show_ends = 1'b0;
  logic             opt_show_tabs = 1'b0;
  logic             opt_nonprint = 1'b0;
  logic             at_bol = 1'b1;
  logic             blank_line = 1'b0;
  logic [BCD_W-1:0] line_bcd = '0;

  int  idle_pct = 9;
  bit  hold_req = 1'b0;
  bit  in_taken = 1'b0;
  int  mismatches = 0;
  int  in_xfers = 0;
  int  out_xfers = 0;
  int  cfg_xfers = 0;
  int  quiet_cycles = 0;

  task automatic put(input logic [7:0] b);
    run_q.push_back(b);
  endtask

  task automatic count_line();
    logic all_nines;
    logic carry;
    all_nines = 1'b1;
    carry = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (line_bcd[4*i +: 4] != 4'd9) all_nines = 1'b0;
    end
    if (!all_nines) begin
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
        if (carry) begin
          if (line_bcd[4*i +: 4] == 4'd9) begin
            line_bcd[4*i +: 4] = 4'd0;
          end else begin
            line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
            carry = 1'b0;
          end
        end
      end
    end
  endtask

  task automatic put_number();
    logic       lead;
    logic [3:0] d;
    lead = 1'b1;
    for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
      d = line_bcd[4*i +: 4];
      if (d != 4'd0 || i == 0) lead = 1'b0;
      put(lead ? CH_SPACE : CH_ZERO + {4'd0, d});
    end
    put(CH_TAB);
  endtask

  task automatic put_visible(input logic [7:0] c);
    logic [6:0] low;
    low = c[6:0];
    if (c[7]) begin
      put(CH_M);
      put(CH_DASH);
    end
    if (low <= CTRL_LAST || low == CH_DEL) begin
      put(CH_CARET);
      put(low == CH_DEL ? CH_QMARK : {1'b0, low} + CARET_OFS);
    end else begin
      put({1'b0, low});
    end
  endtask

  task automatic format_byte(input in_item_t it);
    logic [7:0] c;
    logic       was_blank;
    out_item_t  r;
    c = it.in_byte;
    run_q.delete();
    if (it.first_of_file) begin
      at_bol = 1'b1;
      blank_line = 1'b0;
      line_bcd = '0;
    end
    if (at_bol) begin
      was_blank = blank_line;
      blank_line = (c == CH_LF);
      if (opt_squeeze && blank_line && was_blank) return;
      if ((opt_nonblank && !blank_line) || (opt_number_all && !opt_nonblank)) begin
        count_line();
        put_number();
      end
      at_bol = 1'b0;
    end
    if (c == CH_LF) begin
      if (opt_show_ends) put(CH_DOLLAR);
      put(CH_LF);
      at_bol = 1'b1;
    end else if (c == CH_TAB) begin
      if (opt_show_tabs) begin
        put(CH_CARET);
        put(CH_I);
      end else begin
        put(CH_TAB);
      end
    end else if (opt_nonprint) begin
      put_visible(c);
    end else begin
      put(c);
    end
    foreach (run_q[k]) begin
      r.out_byte = run_q[k];
      r.last_of_run = (k == run_q.size() - 1);
      fmt_expect.push_back(r);
    end
  endtask

  // monitor: outputs checked first, then the accepted input is predicted
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        out_xfers++;
        if (fmt_expect.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected output transfer: byte %h last %b",
                     out_data.out_byte, out_data.last_of_run);
        end else if (out_data !== fmt_expect[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at output %0d: expected byte %h last %b, got byte %h last %b",
                     out_xfers, fmt_expect[0].out_byte, fmt_expect[0].last_of_run,
                     out_data.out_byte, out_data.last_of_run);
          void'(fmt_expect.pop_front());
        end else begin
          void'(fmt_expect.pop_front());
        end
      end
      if (in_push && !in_full) begin
        in_taken = 1'b1;
        in_xfers++;
        format_byte(in_data);
      end
      if (cfg_valid && cfg_ready) begin
        cfg_xfers++;
        case (cfg_index)
          CFG_NUMBER_ALL: opt_number_all = cfg_data;
          CFG_NUMBER_NONBLANK: opt_nonblank = cfg_data;
          CFG_SQUEEZE: opt_squeeze = cfg_data;
          CFG_SHOW_ENDS: opt_show_ends = cfg_data;
          CFG_SHOW_TABS: opt_show_tabs = cfg_data;
          CFG_SHOW_NONPRINT: opt_nonprint = cfg_data;
          default: ;
        endcase
      end
      if ((out_pop && !out_empty) || in_taken || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, fmt_expect.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (!in_push || in_taken) begin
      if (text_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_data <= text_q.pop_front();
        in_push <= 1'b1;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off on request
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_pop <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // bit order follows the register indexes
  task automatic set_options(input logic [5:0] opts);
    write_reg(CFG_NUMBER_ALL, opts[0]);
    write_reg(CFG_NUMBER_NONBLANK, opts[1]);
    write_reg(CFG_SQUEEZE, opts[2]);
    write_reg(CFG_SHOW_ENDS, opts[3]);
    write_reg(CFG_SHOW_TABS, opts[4]);
    write_reg(CFG_SHOW_NONPRINT, opts[5]);
  endtask

  task automatic drain();
    @(posedge clk);
    while (text_q.size() > 0 || in_push || fmt_expect.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add(input logic [7:0] b, input logic fof);
    in_item_t it;
    it.in_byte = b;
    it.first_of_file = fof;
    text_q.push_back(it);
  endtask

  function automatic logic [7:0] text_char();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 8'($urandom_range(126, 32));
    else if (r < 65) return CH_TAB;
    else if (r < 75) return 8'($urandom_range(31, 0));
    else if (r < 79) return {1'b0, CH_DEL};
    else return 8'($urandom_range(255, 128));
  endfunction

  task automatic add_text(ref int n);
    int  r;
    int  len;
    logic fof;
    r = $urandom_range(99);
    fof = ($urandom_range(99) < 6);
    if (r < 8) begin
      len = $urandom_range(3, 1);
      repeat (len) add(8'($urandom), 1'($urandom));
      n += len;
    end else if (r < 38) begin
      add(CH_LF, fof);
      n++;
    end else begin
      len = $urandom_range(10, 1);
      add(text_char(), fof);
      repeat (len - 1) add(text_char(), 1'b0);
      add(CH_LF, 1'b0);
      n += len + 1;
    end
  endtask

  initial begin
    int n;
    int phase;
    logic [5:0] opts;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // options at reset: raw pass-through
    add(8'h00, 1'b1);
    add(8'hff, 1'b0);
    add("A", 1'b0);
    add(CH_TAB, 1'b0);
    add({1'b0, CH_DEL}, 1'b0);
    add(8'h80, 1'b0);
    add(CH_LF, 1'b0);
    drain();

    // everything shown; the first blank line stays, the two after it are squeezed
    set_options(6'b111101);
    write_reg(CFG_SPARE, 1'b1);
    add(CH_LF, 1'b1);
    add(CH_LF, 1'b0);
    add(CH_LF, 1'b0);
    add(8'h01, 1'b0);
    add(CH_TAB, 1'b0);
    add(8'h9f, 1'b0);
    add(8'ha0, 1'b0);
    add(8'hfe, 1'b0);
    add(8'hff, 1'b0);
    add({1'b0, CH_DEL}, 1'b0);
    add(CH_LF, 1'b0);
    drain();

    // tab and newline pass through with non-printing display and nonblank numbering on
    set_options(6'b100011);
    add(CH_TAB, 1'b0);
    add(CH_LF, 1'b0);
    add(CH_LF, 1'b0);
    add("z", 1'b0);
    add(CH_LF, 1'b0);
    drain();

    n = 0;
    phase = 0;
    while (n < RANDOM_ITEMS) begin
      case (phase)
        0: opts = 6'b000000;
        1: opts = 6'b111111;
        2: opts = 6'b100110;
        default: opts = 6'($urandom);
      endcase
      set_options(opts);
      idle_pct = (phase == 3) ? 0 : 9;
      repeat (12) add_text(n);
      if (phase == 4) hold_req = 1'b1;
      drain();
      phase++;
    end

    idle_pct = 9;
    repeat (20) @(posedge clk);
    $display("run covered %0d input and %0d output transfers over %0d register writes",
             in_xfers, out_xfers, cfg_xfers);
    $display("%0d mismatches, %0d results never arrived", mismatches, fmt_expect.size());
    if (mismatches == 0 && fmt_expect.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
